/* src/button_click_qualifier_macros.svh */
// Assertion macros shared by the button click qualifier RTL.
`ifndef BUTTON_CLICK_QUALIFIER_MACROS_SVH
`define BUTTON_CLICK_QUALIFIER_MACROS_SVH

// Same-cycle implication, checked on aclk, muted during reset.
`define BCQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, muted during reset.
`define BCQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bcq_pkg.sv */
// Shared constants, codes and types of the button click qualifier.
`default_nettype none

package bcq_pkg;

    localparam int NBTN      = 3;
    localparam int TICK_BITS = 16;
    localparam int WIN_BITS  = 16;
    localparam int POS_BITS  = 16;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 16'd500;

    // Item kinds carried in tuser
    localparam logic [2:0] KIND_BUTTON = 3'd0;
    localparam logic [2:0] KIND_CLEAR  = 3'd1;
    localparam logic [2:0] KIND_POS    = 3'd2;
    localparam logic [2:0] KIND_SCROLL = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // Button indexes
    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;
    localparam logic [1:0] BTN_MID   = 2'd2;

    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 48;

    // Command to one button tracker for the item being processed
    typedef struct packed {
        logic report;
        logic is_down;
        logic clear;
        logic clear_pressed;
        logic clear_released;
        logic clear_held;
        logic tick;
    } bcq_btn_cmd_t;

    // Flags of one button after the item, plus a cursor capture request
    typedef struct packed {
        logic held;
        logic pressed;
        logic released;
        logic double_click;
        logic capture;
    } bcq_btn_flags_t;

endpackage

`default_nettype wire

/* src/button_click_qualifier.sv */
// Top level of the button click qualifier: stream ports, shared cursor state, result register.
//
// Usage:
//   Input stream (s_*): one transaction per pointer event. s_tuser carries the
//   event kind (button report, clear, position, scroll, tick); s_tdata the
//   event fields. Every input transaction yields exactly one output
//   transaction (m_*) carrying the button masks, scroll flags and cursor as
//   they stand after that event.
//   Configuration: pulse cfg_we with cfg_wdata to set the double-click window
//   in ticks; write only while no transaction is in flight.
//   Path: a transaction goes from s_* through the input register and the
//   result register to m_*. Throughput: one transaction per cycle while
//   m_tready stays high; the pace is set by the single pass from the input
//   register through the per-button update logic into the result register.
//   Stall: while m_tready is low the result holds, the input register keeps
//   one more transaction, and s_tready drops once both are full.
//   Reset: aresetn (synchronous, active low) empties both registers, clears
//   all flags, counters and cursor, sets the stored click position to -1 and
//   the window to 500 ticks.
`default_nettype none
`include "button_click_qualifier_macros.svh"

module button_click_qualifier
    import bcq_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration: double-click window
    input  wire logic                    cfg_we,
    input  wire logic [WIN_BITS-1:0]     cfg_wdata,
    // Input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [1:0] button, [2] is_down, [3] clear_pressed, [4] clear_released,
    // [5] clear_held, [21:6] pos_x, [37:22] pos_y, [38] wheel_up,
    // [39] wheel_down
    input  wire logic [S_DATA_BITS-1:0]  s_tdata,
    // [2:0] kind
    input  wire logic [2:0]              s_tuser,
    // Result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [2:0] held_mask, [5:3] pressed_mask, [8:6] released_mask,
    // [11:9] double_mask, [12] scrolled_up, [13] scrolled_down,
    // [29:14] cursor_x, [45:30] cursor_y, [47:46] zero
    output logic [M_DATA_BITS-1:0]       m_tdata
);

    // Input register
    logic                   in_valid_reg;
    logic [S_DATA_BITS-1:0] in_data_reg;
    logic [2:0]             in_kind_reg;

    // Result register
    logic                   out_valid_reg;
    logic [M_DATA_BITS-1:0] out_data_reg, out_data_next;

    // Shared state
    logic [WIN_BITS-1:0] window_reg;
    logic [POS_BITS-1:0] click_x_reg, click_x_next;
    logic [POS_BITS-1:0] click_y_reg, click_y_next;
    logic [POS_BITS-1:0] cur_x_reg, cur_x_next;
    logic [POS_BITS-1:0] cur_y_reg, cur_y_next;
    logic                up_reg, up_next;
    logic                down_reg, down_next;

    // Decoded input fields
    logic [1:0]          f_button;
    logic                f_is_down;
    logic                f_clear_pressed;
    logic                f_clear_released;
    logic                f_clear_held;
    logic [POS_BITS-1:0] f_pos_x;
    logic [POS_BITS-1:0] f_pos_y;
    logic                f_wheel_up;
    logic                f_wheel_down;

    logic                advance;
    logic                fire;
    logic [1:0]          btn_sel;
    logic                is_report, is_clear, is_pos, is_scroll, is_tick;
    logic                pos_match;
    logic                any_capture;

    bcq_btn_cmd_t        cmd   [NBTN];
    bcq_btn_flags_t      flags [NBTN];
    logic [NBTN-1:0]     held_mask, pressed_mask, released_mask, double_mask;

    assign f_button         = in_data_reg[1:0];
    assign f_is_down        = in_data_reg[2];
    assign f_clear_pressed  = in_data_reg[3];
    assign f_clear_released = in_data_reg[4];
    assign f_clear_held     = in_data_reg[5];
    assign f_pos_x          = in_data_reg[21:6];
    assign f_pos_y          = in_data_reg[37:22];
    assign f_wheel_up       = in_data_reg[38];
    assign f_wheel_down     = in_data_reg[39];

    // Advance the pipe whenever the result slot is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Decode the event kind; unused kinds change nothing
    always_comb begin
        is_report = 1'b0;
        is_clear  = 1'b0;
        is_pos    = 1'b0;
        is_scroll = 1'b0;
        is_tick   = 1'b0;
        unique case (in_kind_reg)
            KIND_BUTTON: is_report = 1'b1;
            KIND_CLEAR:  is_clear  = 1'b1;
            KIND_POS:    is_pos    = 1'b1;
            KIND_SCROLL: is_scroll = 1'b1;
            KIND_TICK:   is_tick   = 1'b1;
            default:     ;
        endcase
    end

    // Map button index three onto the middle button
    always_comb begin
        unique case (f_button)
            BTN_LEFT:  btn_sel = BTN_LEFT;
            BTN_RIGHT: btn_sel = BTN_RIGHT;
            default:   btn_sel = BTN_MID;
        endcase
    end

    assign pos_match = (click_x_reg == cur_x_reg) && (click_y_reg == cur_y_reg);

    genvar gi;
    generate
        for (gi = 0; gi < NBTN; gi++) begin : g_btn
            assign cmd[gi].report         = is_report && (btn_sel == 2'(gi));
            assign cmd[gi].is_down        = f_is_down;
            assign cmd[gi].clear          = is_clear;
            assign cmd[gi].clear_pressed  = f_clear_pressed;
            assign cmd[gi].clear_released = f_clear_released;
            assign cmd[gi].clear_held     = f_clear_held;
            assign cmd[gi].tick           = is_tick;

            bcq_button u_button (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .fire       (fire),
                .cmd        (cmd[gi]),
                .window     (window_reg),
                .pos_match  (pos_match),
                .flags_next (flags[gi])
            );

            assign held_mask[gi]     = flags[gi].held;
            assign pressed_mask[gi]  = flags[gi].pressed;
            assign released_mask[gi] = flags[gi].released;
            assign double_mask[gi]   = flags[gi].double_click;
        end
    endgenerate

    // Only the reported button can request a capture
    assign any_capture = flags[0].capture || flags[1].capture || flags[2].capture;

    always_comb begin
        click_x_next = click_x_reg;
        click_y_next = click_y_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        // Store the cursor seen at the release that opens a wait
        if (any_capture) begin
            click_x_next = cur_x_reg;
            click_y_next = cur_y_reg;
        end
        if (is_pos) begin
            cur_x_next = f_pos_x;
            cur_y_next = f_pos_y;
        end
        if (is_scroll) begin
            up_next   = f_wheel_up;
            down_next = f_wheel_down;
        end
        // Drop both scroll flags on a clear
        if (is_clear) begin
            up_next   = 1'b0;
            down_next = 1'b0;
        end
    end

    assign out_data_next = {2'b00, cur_y_next, cur_x_next, down_next, up_next,
                            double_mask, released_mask, pressed_mask, held_mask};

    // Input register: load on every accepted transaction, empty when it moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // Shared state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RESET;
            click_x_reg <= '1;
            click_y_reg <= '1;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            up_reg      <= 1'b0;
            down_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            if (fire) begin
                click_x_reg <= click_x_next;
                click_y_reg <= click_y_next;
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                up_reg      <= up_next;
                down_reg    <= down_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `BCQ_ASSERT_NOW(a_ready_when_result_free, !out_valid_reg, s_tready, "input stalled with free result slot")
    `BCQ_ASSERT_NEXT(a_fire_fills_result, fire, out_valid_reg, "processed transaction lost")
    `BCQ_ASSERT_NEXT(a_clear_drops_double, fire && is_clear, (m_tdata[11:9] == 3'b000) && (m_tdata[13:12] == 2'b00), "clear left double or scroll flags set")

endmodule

`default_nettype wire

/* src/bcq_button.sv */
// Per-button state tracker: held/pressed/released flags and double-click timing.
`default_nettype none

module bcq_button
    import bcq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  wire bcq_btn_cmd_t         cmd,
    input  wire logic [WIN_BITS-1:0]  window,
    input  wire logic                 pos_match,
    output bcq_btn_flags_t            flags_next
);

    localparam int CMP_BITS = (TICK_BITS > WIN_BITS) ? TICK_BITS : WIN_BITS;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    logic held_reg, held_next;
    logic pressed_reg, pressed_next;
    logic lock_reg, lock_next;
    logic released_reg, released_next;
    logic double_reg, double_next;
    logic waiting_reg, waiting_next;
    logic allowed_reg, allowed_next;
    logic [TICK_BITS-1:0] ticks_reg, ticks_next;

    logic [CMP_BITS-1:0] ticks_ext;
    logic [CMP_BITS-1:0] window_ext;
    logic                capture;

    assign ticks_ext  = CMP_BITS'(ticks_reg);
    assign window_ext = CMP_BITS'(window);

    always_comb begin
        held_next     = held_reg;
        pressed_next  = pressed_reg;
        lock_next     = lock_reg;
        released_next = released_reg;
        double_next   = double_reg;
        waiting_next  = waiting_reg;
        allowed_next  = allowed_reg;
        ticks_next    = ticks_reg;
        capture       = 1'b0;

        if (cmd.report) begin
            held_next     = cmd.is_down;
            released_next = !cmd.is_down;
            lock_next     = cmd.is_down;
            if (!lock_reg) begin
                pressed_next = cmd.is_down;
            end
            if (!cmd.is_down) begin
                if (allowed_reg) begin
                    waiting_next = 1'b1;
                    capture      = 1'b1;
                end else begin
                    allowed_next = 1'b1;
                end
                ticks_next = '0;
            end else if (pressed_next && waiting_reg) begin
                if ((ticks_ext < window_ext) && pos_match) begin
                    double_next = 1'b1;
                end
                waiting_next = 1'b0;
                allowed_next = 1'b0;
            end
        end else if (cmd.clear) begin
            if (cmd.clear_pressed) begin
                pressed_next = 1'b0;
            end
            if (cmd.clear_released) begin
                released_next = 1'b0;
            end
            if (cmd.clear_held) begin
                held_next = 1'b0;
            end
            double_next = 1'b0;
            if (ticks_ext > window_ext) begin
                waiting_next = 1'b0;
            end
        end else if (cmd.tick) begin
            if (ticks_reg != TICK_MAX) begin
                ticks_next = ticks_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= 1'b0;
            pressed_reg  <= 1'b0;
            lock_reg     <= 1'b0;
            released_reg <= 1'b0;
            double_reg   <= 1'b0;
            waiting_reg  <= 1'b0;
            allowed_reg  <= 1'b1;
            ticks_reg    <= '0;
        end else if (fire) begin
            held_reg     <= held_next;
            pressed_reg  <= pressed_next;
            lock_reg     <= lock_next;
            released_reg <= released_next;
            double_reg   <= double_next;
            waiting_reg  <= waiting_next;
            allowed_reg  <= allowed_next;
            ticks_reg    <= ticks_next;
        end
    end

    assign flags_next.held         = held_next;
    assign flags_next.pressed      = pressed_next;
    assign flags_next.released     = released_next;
    assign flags_next.double_click = double_next;
    assign flags_next.capture      = capture;

endmodule

`default_nettype wire
